@@ src/csyr_pkg.sv @@
// Shared constants, types and fixed-point helpers for the complex symmetric
// rank-1 update block. No dependencies.

package csyr_pkg;

   localparam int MAX_ORDER = 64;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int ORDER_W   = 7;
   localparam int ADDR_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int CNT_W     = $clog2(MAX_ORDER + 1);
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int NARROW_W  = 42;
   localparam int SHIFT     = (FRAC_BITS == 0) ? 0 : FRAC_BITS - 1;

   localparam logic signed [SUM_W-1:0]  LIM_WIDE = {{(SUM_W-41){1'b0}}, 1'b1, 40'b0};
   localparam logic signed [NARROW_W:0] LIM_MID  = {{(NARROW_W-40){1'b0}}, 1'b1, 40'b0};
   localparam logic signed [NARROW_W:0] WORD_MAX = (NARROW_W+1)'(32'sh7FFF_FFFF);
   localparam logic signed [NARROW_W:0] WORD_MIN = (NARROW_W+1)'(32'sh8000_0000);

   typedef enum logic [1:0] {
      CSR_ALPHA_REAL,
      CSR_ALPHA_IMAG,
      CSR_LOWER,
      CSR_ORDER
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE_MUL,
      ST_SCALE_SUM,
      ST_ELEM_MUL,
      ST_ELEM_SUM
   } state_type;

   typedef struct packed {
      logic mul_en;
      logic mul_scale;
      logic scale_en;
   } dp_ctrl_type;

   typedef struct packed {
      logic                     clip;
      logic signed [DATA_W-1:0] value;
   } sat_type;

   // floor(s / 2^FRAC_BITS) through a halved, clamped intermediate
   function automatic logic signed [NARROW_W-1:0] sum_shift(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0]  h;
      logic signed [NARROW_W:0] hc;
      logic signed [NARROW_W:0] v;
      h = s >>> 1;
      if (h > LIM_WIDE) begin
         hc = LIM_MID;
      end else if (h < -LIM_WIDE) begin
         hc = -LIM_MID;
      end else begin
         hc = h[NARROW_W:0];
      end
      if (FRAC_BITS == 0) begin
         v = {hc[NARROW_W-1:0], s[0]};
      end else begin
         v = hc >>> SHIFT;
      end
      if (v > LIM_MID) begin
         v = LIM_MID;
      end else if (v < -LIM_MID) begin
         v = -LIM_MID;
      end
      return v[NARROW_W-1:0];
   endfunction

   function automatic sat_type saturate(input logic signed [NARROW_W:0] v);
      sat_type r;
      if (v > WORD_MAX) begin
         r.clip  = 1'b1;
         r.value = WORD_MAX[DATA_W-1:0];
      end else if (v < WORD_MIN) begin
         r.clip  = 1'b1;
         r.value = WORD_MIN[DATA_W-1:0];
      end else begin
         r.clip  = 1'b0;
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ src/csyr_vector_ram.sv @@
// Vector store: one write port, two registered read ports.
// Depends on csyr_pkg.

module csyr_vector_ram (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [csyr_pkg::ADDR_W-1:0]     wr_addr,
   input  logic [2*csyr_pkg::DATA_W-1:0]   wr_data,
   input  logic                            rd_en,
   input  logic [csyr_pkg::ADDR_W-1:0]     rd_addr_row,
   input  logic [csyr_pkg::ADDR_W-1:0]     rd_addr_col,
   output logic [2*csyr_pkg::DATA_W-1:0]   rd_data_row,
   output logic [2*csyr_pkg::DATA_W-1:0]   rd_data_col
);
   import csyr_pkg::*;

   logic [2*DATA_W-1:0] vec_mem [MAX_ORDER];
   logic [2*DATA_W-1:0] rd_row_ff;
   logic [2*DATA_W-1:0] rd_col_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vec_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= vec_mem[rd_addr_row];
         rd_col_ff <= vec_mem[rd_addr_col];
      end
   end

   assign rd_data_row = rd_row_ff;
   assign rd_data_col = rd_col_ff;

endmodule

@@ src/csyr_cmac.sv @@
// Shared complex multiplier with column scale register and saturating add.
// Depends on csyr_pkg.

module csyr_cmac (
   input  logic                                 clock,
   input  csyr_pkg::dp_ctrl_type                ctrl,
   input  logic signed [csyr_pkg::DATA_W-1:0]   alpha_real,
   input  logic signed [csyr_pkg::DATA_W-1:0]   alpha_imag,
   input  logic [2*csyr_pkg::DATA_W-1:0]        x_row,
   input  logic [2*csyr_pkg::DATA_W-1:0]        x_col,
   input  logic signed [csyr_pkg::DATA_W-1:0]   elem_real,
   input  logic signed [csyr_pkg::DATA_W-1:0]   elem_imag,
   output logic signed [csyr_pkg::DATA_W-1:0]   res_real,
   output logic signed [csyr_pkg::DATA_W-1:0]   res_imag,
   output logic                                 res_sat
);
   import csyr_pkg::*;

   logic signed [DATA_W-1:0]   a_re, a_im, b_re, b_im;
   logic signed [PROD_W-1:0]   prod_rr_ff, prod_ii_ff, prod_ri_ff, prod_ir_ff;
   logic signed [SUM_W-1:0]    sum_re, sum_im;
   logic signed [NARROW_W-1:0] term_re, term_im;
   logic signed [DATA_W-1:0]   scale_real_ff, scale_imag_ff;
   logic                       scale_clip_ff;
   sat_type                    scl_re, scl_im, out_re, out_im;

   always_comb begin
      if (ctrl.mul_scale) begin
         a_re = alpha_real;
         a_im = alpha_imag;
         b_re = $signed(x_col[DATA_W-1:0]);
         b_im = $signed(x_col[2*DATA_W-1:DATA_W]);
      end else begin
         a_re = $signed(x_row[DATA_W-1:0]);
         a_im = $signed(x_row[2*DATA_W-1:DATA_W]);
         b_re = scale_real_ff;
         b_im = scale_imag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_rr_ff <= a_re * b_re;
         prod_ii_ff <= a_im * b_im;
         prod_ri_ff <= a_re * b_im;
         prod_ir_ff <= a_im * b_re;
      end
   end

   assign sum_re  = SUM_W'(prod_rr_ff) - SUM_W'(prod_ii_ff);
   assign sum_im  = SUM_W'(prod_ri_ff) + SUM_W'(prod_ir_ff);
   assign term_re = sum_shift(sum_re);
   assign term_im = sum_shift(sum_im);

   assign scl_re = saturate((NARROW_W+1)'(term_re));
   assign scl_im = saturate((NARROW_W+1)'(term_im));

   // hold the scale for the whole column
   always_ff @(posedge clock) begin
      if (ctrl.scale_en) begin
         scale_real_ff <= scl_re.value;
         scale_imag_ff <= scl_im.value;
         scale_clip_ff <= scl_re.clip | scl_im.clip;
      end
   end

   assign out_re = saturate((NARROW_W+1)'(elem_real) + (NARROW_W+1)'(term_re));
   assign out_im = saturate((NARROW_W+1)'(elem_imag) + (NARROW_W+1)'(term_im));

   assign res_real = out_re.value;
   assign res_imag = out_im.value;
   assign res_sat  = out_re.clip | out_im.clip | scale_clip_ff;

endmodule

@@ src/complex_symmetric_rank1_update.sv @@
// Top level of the complex symmetric rank-1 update: registers, index
// sequencer, state machine and result register.
// Depends on csyr_pkg, csyr_vector_ram and csyr_cmac.
//
// Usage:
//  - Configure alpha, the triangle and the order through the csr_ write port
//    while the block is idle; a triangle or order write restarts all indices.
//  - Mode 0 requests load the vector x in logical order, one element each; a
//    load gives no result.
//  - Mode 1 requests bring the triangle's elements in column order; each gives
//    one result on the rsp_ channel: elem + x_i * (alpha * x_j), saturated.
//  - Each update passes through the element product and sum states to the result
//    register; on the first element of a column, alpha * x_j is first formed on
//    the same four 32x32 multipliers before the element product. Loads run at
//    1 per cycle while no update is in progress.
//  - The vector sits in a 64-entry memory with registered reads, read at the
//    row and column address when an update request is taken.
//  - The next request is taken in the cycle the result enters the output
//    register; while that register is full and stalled, the block holds.
//  - Reset clears the configuration registers, indices and output valid; the vector store
//    keeps its contents and needs no clearing pass.

module complex_symmetric_rank1_update (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic signed [csyr_pkg::DATA_W-1:0]   req_vec_real,
   input  logic signed [csyr_pkg::DATA_W-1:0]   req_vec_imag,
   input  logic signed [csyr_pkg::DATA_W-1:0]   req_elem_real,
   input  logic signed [csyr_pkg::DATA_W-1:0]   req_elem_imag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [csyr_pkg::DATA_W-1:0]   rsp_new_real,
   output logic signed [csyr_pkg::DATA_W-1:0]   rsp_new_imag,
   output logic                                 rsp_last_of_triangle,
   output logic                                 rsp_saturated,
   input  logic                                 csr_we,
   input  csyr_pkg::csr_index_type              csr_index,
   input  logic [csyr_pkg::DATA_W-1:0]          csr_wdata
);
   import csyr_pkg::*;

   logic signed [DATA_W-1:0] alpha_real_ff, alpha_real_in;
   logic signed [DATA_W-1:0] alpha_imag_ff, alpha_imag_in;
   logic                     lower_ff, lower_in;
   logic [ORDER_W-1:0]       order_ff, order_in;
   logic [ADDR_W-1:0]        load_ff, load_in;
   logic [ADDR_W-1:0]        row_ff, row_in;
   logic [ADDR_W-1:0]        col_ff, col_in;
   state_type                state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [DATA_W-1:0] elem_real_ff, elem_real_in;
   logic signed [DATA_W-1:0] elem_imag_ff, elem_imag_in;
   logic                     bypass_ff, bypass_in;
   logic                     last_ff, last_in;
   logic signed [DATA_W-1:0] rsp_real_ff, rsp_real_in;
   logic signed [DATA_W-1:0] rsp_imag_ff, rsp_imag_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   logic [CNT_W-1:0]         n_eff, row_w, col_w, load_w;
   logic [CNT_W-1:0]         row_inc, col_inc, load_inc, row_nx, col_nx;
   logic                     in_range, first, wrap, load_ok;
   logic                     accept, upd_acc, out_free, rsp_load;
   state_type                upd_target;
   dp_ctrl_type              dp_ctrl;
   logic [2*DATA_W-1:0]      x_row, x_col;
   logic signed [DATA_W-1:0] res_real, res_imag;
   logic                     res_sat;

   assign n_eff = (32'(order_ff) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(order_ff);
   assign row_w    = CNT_W'(row_ff);
   assign col_w    = CNT_W'(col_ff);
   assign load_w   = CNT_W'(load_ff);
   assign row_inc  = row_w + CNT_W'(1);
   assign col_inc  = col_w + CNT_W'(1);
   assign load_inc = load_w + CNT_W'(1);

   assign in_range = (n_eff != '0) && (row_w < n_eff) && (col_w < n_eff);
   assign first    = lower_ff ? (row_ff == col_ff) : (row_ff == '0);
   assign load_ok  = (n_eff != '0) && (load_w < n_eff);

   always_comb begin
      if (lower_ff) begin
         if (row_inc >= n_eff) begin
            col_nx = col_inc;
            row_nx = col_inc;
         end else begin
            col_nx = col_w;
            row_nx = row_inc;
         end
      end else begin
         if (row_w >= col_w) begin
            col_nx = col_inc;
            row_nx = '0;
         end else begin
            col_nx = col_w;
            row_nx = row_inc;
         end
      end
   end

   assign wrap       = col_nx >= n_eff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign upd_acc    = accept && req_mode;
   assign upd_target = (first && in_range) ? ST_SCALE_MUL : ST_ELEM_MUL;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (upd_acc) begin
               state_in = upd_target;
            end
         end
         ST_SCALE_MUL: state_in = ST_SCALE_SUM;
         ST_SCALE_SUM: state_in = ST_ELEM_MUL;
         ST_ELEM_MUL:  state_in = ST_ELEM_SUM;
         ST_ELEM_SUM: begin
            if (out_free) begin
               state_in = upd_acc ? upd_target : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      dp_ctrl   = '0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SCALE_MUL: begin
            dp_ctrl.mul_en    = 1'b1;
            dp_ctrl.mul_scale = 1'b1;
         end
         ST_SCALE_SUM: dp_ctrl.scale_en = 1'b1;
         ST_ELEM_MUL:  dp_ctrl.mul_en = 1'b1;
         ST_ELEM_SUM: begin
            req_ready = out_free;
            rsp_load  = out_free;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // registers, indices and request capture
   always_comb begin
      alpha_real_in = alpha_real_ff;
      alpha_imag_in = alpha_imag_ff;
      lower_in      = lower_ff;
      order_in      = order_ff;
      load_in       = load_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      elem_real_in  = elem_real_ff;
      elem_imag_in  = elem_imag_ff;
      bypass_in     = bypass_ff;
      last_in       = last_ff;

      if (accept && !req_mode) begin
         load_in = (load_ok && load_inc < n_eff) ? load_inc[ADDR_W-1:0] : '0;
      end
      if (upd_acc) begin
         elem_real_in = req_elem_real;
         elem_imag_in = req_elem_imag;
         bypass_in    = !in_range;
         last_in      = wrap;
         if (in_range) begin
            row_in = wrap ? '0 : row_nx[ADDR_W-1:0];
            col_in = wrap ? '0 : col_nx[ADDR_W-1:0];
         end
      end

      if (csr_we) begin
         case (csr_index)
            CSR_ALPHA_REAL: alpha_real_in = $signed(csr_wdata);
            CSR_ALPHA_IMAG: alpha_imag_in = $signed(csr_wdata);
            CSR_LOWER: begin
               lower_in = csr_wdata[0];
               load_in  = '0;
               row_in   = '0;
               col_in   = '0;
            end
            CSR_ORDER: begin
               order_in = csr_wdata[ORDER_W-1:0];
               load_in  = '0;
               row_in   = '0;
               col_in   = '0;
            end
            default: order_in = order_ff;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_real_in  = rsp_real_ff;
      rsp_imag_in  = rsp_imag_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (rsp_load) begin
         rsp_real_in = bypass_ff ? elem_real_ff : res_real;
         rsp_imag_in = bypass_ff ? elem_imag_ff : res_imag;
         rsp_last_in = !bypass_ff && last_ff;
         rsp_sat_in  = !bypass_ff && res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_real_ff <= '0;
         alpha_imag_ff <= '0;
         lower_ff      <= 1'b0;
         order_ff      <= '0;
         load_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         alpha_real_ff <= alpha_real_in;
         alpha_imag_ff <= alpha_imag_in;
         lower_ff      <= lower_in;
         order_ff      <= order_in;
         load_ff       <= load_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_real_ff <= elem_real_in;
      elem_imag_ff <= elem_imag_in;
      bypass_ff    <= bypass_in;
      last_ff      <= last_in;
      rsp_real_ff  <= rsp_real_in;
      rsp_imag_ff  <= rsp_imag_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   csyr_vector_ram u_ram (
      .clock       (clock),
      .wr_en       (accept && !req_mode && load_ok),
      .wr_addr     (load_ff),
      .wr_data     ({req_vec_imag, req_vec_real}),
      .rd_en       (upd_acc),
      .rd_addr_row (row_ff),
      .rd_addr_col (col_ff),
      .rd_data_row (x_row),
      .rd_data_col (x_col)
   );

   csyr_cmac u_cmac (
      .clock      (clock),
      .ctrl       (dp_ctrl),
      .alpha_real (alpha_real_ff),
      .alpha_imag (alpha_imag_ff),
      .x_row      (x_row),
      .x_col      (x_col),
      .elem_real  (elem_real_ff),
      .elem_imag  (elem_imag_ff),
      .res_real   (res_real),
      .res_imag   (res_imag),
      .res_sat    (res_sat)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_new_real         = rsp_real_ff;
   assign rsp_new_imag         = rsp_imag_ff;
   assign rsp_last_of_triangle = rsp_last_ff;
   assign rsp_saturated        = rsp_sat_ff;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (n_eff != '0) |-> (row_w < n_eff) && (col_w < n_eff))
      else $error("row or column index beyond the order");

   a_index_triangle: assert property (@(posedge clock) disable iff (reset)
      (n_eff != '0) |-> (lower_ff ? (row_ff >= col_ff) : (row_ff <= col_ff)))
      else $error("index pair outside the selected triangle");

   a_scale_then_elem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE_MUL) |-> ##2 (state_ff == ST_ELEM_MUL))
      else $error("column scale not followed by the element product");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ELEM_SUM))
      else $error("result raised outside the final stage");

endmodule
